// File: rtl/dbd_pkg.sv
// Package for the day count between two dates: field widths, payload structs,
// multiplier constants and the month offset table.
// No dependencies; every other file of the block imports it.
package dbd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 22;

    // Linear day numbers stay below 6.1 million for any 14-bit year.
    localparam int ACC_W = 24;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 15;
    localparam int MUL_K_W = 13;
    localparam int MUL_P_W = MUL_A_W + MUL_K_W;

    // floor(x / 100) = (x * 5243) >> 19 holds for every x below 2^15.
    localparam logic [MUL_K_W-1:0] RECIP_100   = 13'd5243;
    localparam int                 RECIP_SHIFT = 19;
    localparam logic [MUL_K_W-1:0] K_HUNDRED   = 13'd100;
    localparam logic [MUL_K_W-1:0] K_YEAR_DAYS = 13'd365;

    // Year offsets that round the century, 400-year and 4-year counts up.
    localparam logic [MUL_A_W-1:0] OFS_CENTURY = 15'd99;
    localparam logic [MUL_A_W-1:0] OFS_QUAD    = 15'd399;
    localparam logic [MUL_A_W-1:0] OFS_LEAP4   = 15'd3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_date;

    typedef struct packed {
        t_date first;
        t_date last;
    } t_dates;

    typedef struct packed {
        logic [COUNT_W-1:0] day_count;
        logic               order_error;
    } t_result;

    // Days in the months before the given one of a common year. Month zero
    // counts as January and months past twelve count as December.
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] month);
        logic [8:0] days;
        unique case (month)
            4'd0, 4'd1: days = 9'd0;
            4'd2:       days = 9'd31;
            4'd3:       days = 9'd59;
            4'd4:       days = 9'd90;
            4'd5:       days = 9'd120;
            4'd6:       days = 9'd151;
            4'd7:       days = 9'd181;
            4'd8:       days = 9'd212;
            4'd9:       days = 9'd243;
            4'd10:      days = 9'd273;
            4'd11:      days = 9'd304;
            default:    days = 9'd334;
        endcase
        return days;
    endfunction

endpackage

// File: rtl/dbd_if.sv
// Valid/ready channel interfaces for the date pair input and the day count
// output. Depends on dbd_pkg for the field widths.
interface dbd_in_if import dbd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [YEAR_W-1:0]  end_year;
    logic [MONTH_W-1:0] end_month;
    logic [DAY_W-1:0]   end_day;

    modport source (
        output valid, start_year, start_month, start_day,
        output end_year, end_month, end_day,
        input  ready
    );
    modport sink (
        input  valid, start_year, start_month, start_day,
        input  end_year, end_month, end_day,
        output ready
    );
endinterface

interface dbd_out_if import dbd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] day_count;
    logic               order_error;

    modport source (output valid, day_count, order_error, input ready);
    modport sink (input valid, day_count, order_error, output ready);
endinterface

// File: rtl/days_between_dates.sv
// Days from a start date to an end date in the Gregorian calendar.
// Each input transfer is worked in six steps of the shared multiplier for each
// date plus a compare step, which waits while the output register is held.
// Date pairs are taken one at a time; input ready is low while busy.
// Reset: synchronous, active low; clears the busy flag, the sequencer and output valid.
module days_between_dates import dbd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dbd_in_if.sink    i_in,
    dbd_out_if.source o_out
);

    logic    r_busy, n_busy;
    t_dates  r_dates;
    logic    r_out_valid, n_out_valid;
    t_result r_out;
    logic    in_xfer;
    logic    hold;
    logic    done;
    t_result result;

    assign i_in.ready = !r_busy;
    assign in_xfer    = i_in.valid && !r_busy;
    assign hold       = r_out_valid && !o_out.ready;

    dbd_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_xfer),
        .i_hold   (hold),
        .i_dates  (r_dates),
        .o_done   (done),
        .o_result (result)
    );

    // Busy from an input transfer until the result enters the output register.
    always_comb begin
        n_busy = r_busy;
        if (in_xfer) begin
            n_busy = 1'b1;
        end else if (done) begin
            n_busy = 1'b0;
        end
    end

    // Output register valid flag.
    always_comb begin
        n_out_valid = r_out_valid;
        if (done) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload capture for the date pair and the result.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_dates.first.year  <= i_in.start_year;
            r_dates.first.month <= i_in.start_month;
            r_dates.first.day   <= i_in.start_day;
            r_dates.last.year   <= i_in.end_year;
            r_dates.last.month  <= i_in.end_month;
            r_dates.last.day    <= i_in.end_day;
        end
        if (done) begin
            r_out <= result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.day_count   = r_out.day_count;
    assign o_out.order_error = r_out.order_error;

endmodule

// File: rtl/dbd_mul.sv
// Shared multiplier of the day count sequencer: one operand times a small
// constant, with the product registered. Depends on dbd_pkg.
module dbd_mul import dbd_pkg::*; (
    input  logic               i_clk,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_K_W-1:0] i_k,
    output logic [MUL_P_W-1:0] o_p
);

    logic [MUL_P_W-1:0] r_p;

    // Product register; the result is used in the following cycle.
    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_k);
    end

    assign o_p = r_p;

endmodule

// File: rtl/dbd_seq.sv
// Sequencer and accumulator that turn both dates into linear day numbers with
// the shared multiplier and form the clamped difference. Depends on dbd_pkg
// and dbd_mul.
module dbd_seq import dbd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_hold,
    input  t_dates  i_dates,
    output logic    o_done,
    output t_result o_result
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_M1   = 3'd1;
    localparam logic [2:0] S_M2   = 3'd2;
    localparam logic [2:0] S_M3   = 3'd3;
    localparam logic [2:0] S_M4   = 3'd4;
    localparam logic [2:0] S_M5   = 3'd5;
    localparam logic [2:0] S_M6   = 3'd6;
    localparam logic [2:0] S_CMP  = 3'd7;

    logic [2:0]         r_state, n_state;
    logic               r_sel, n_sel;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [ACC_W-1:0]   r_first, n_first;
    logic               r_q4, n_q4;

    t_date              cur;
    logic [MUL_A_W-1:0] year_x;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_K_W-1:0] mul_k;
    logic [MUL_P_W-1:0] prod;
    logic [8:0]         quot;
    logic               leap;
    logic [ACC_W-1:0]   year_sum;
    logic [ACC_W-1:0]   diff;

    dbd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_k   (mul_k),
        .o_p   (prod)
    );

    // The start date is worked first, then the end date.
    assign cur    = r_sel ? i_dates.last : i_dates.first;
    assign year_x = MUL_A_W'(cur.year);
    assign quot   = prod[RECIP_SHIFT +: 9];

    // Leap year: divisible by 4, and either not by 100 or by 400. The product
    // in the fifth step is 100 * floor(year / 100).
    assign leap = (cur.year[1:0] == 2'b00) &&
                  ((prod[YEAR_W-1:0] != cur.year) || r_q4);

    // Month offset, the day and the rounded-up count of years divisible by 4.
    assign year_sum = ACC_W'(days_before(cur.month)) + ACC_W'(cur.day) +
                      ACC_W'((year_x + OFS_LEAP4) >> 2);

    assign diff = r_acc - r_first;

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = year_x;
        mul_k = RECIP_100;
        unique case (r_state)
            S_M1: mul_a = year_x + OFS_CENTURY;
            S_M2: mul_a = year_x + OFS_QUAD;
            S_M3: mul_a = year_x;
            S_M4: begin
                mul_a = MUL_A_W'(quot);
                mul_k = K_HUNDRED;
            end
            S_M5: mul_k = K_YEAR_DAYS;
            default: begin
                mul_a = year_x;
                mul_k = RECIP_100;
            end
        endcase
    end

    // Step sequence and accumulator updates.
    always_comb begin
        n_state  = r_state;
        n_sel    = r_sel;
        n_acc    = r_acc;
        n_first  = r_first;
        n_q4     = r_q4;
        o_done   = 1'b0;
        o_result = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_M1;
                    n_sel   = 1'b0;
                end
            end
            S_M1: begin
                n_acc   = year_sum;
                n_state = S_M2;
            end
            S_M2: begin
                // Subtract the rounded-up count of century years.
                n_acc   = r_acc - ACC_W'(quot);
                n_state = S_M3;
            end
            S_M3: begin
                // Add back the rounded-up count of 400-year multiples.
                n_acc   = r_acc + ACC_W'(quot >> 2);
                n_state = S_M4;
            end
            S_M4: begin
                n_q4    = (quot[1:0] == 2'b00);
                n_state = S_M5;
            end
            S_M5: begin
                if (leap && (cur.month > 4'd2)) begin
                    n_acc = r_acc + ACC_W'(1);
                end
                n_state = S_M6;
            end
            S_M6: begin
                n_acc = r_acc + prod[ACC_W-1:0];
                if (!r_sel) begin
                    n_first = n_acc;
                    n_sel   = 1'b1;
                    n_state = S_M1;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (!i_hold) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                    if (r_acc < r_first) begin
                        o_result.order_error = 1'b1;
                    end else if (diff > ACC_W'(COUNT_MAX)) begin
                        o_result.day_count = COUNT_MAX;
                    end else begin
                        o_result.day_count = diff[COUNT_W-1:0];
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state is reset; the datapath registers are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_first <= n_first;
        r_q4    <= n_q4;
    end

endmodule
